/* hdl/spncbc_pkg.sv */
// Package: shared types, constants and byte substitution for the SPN CBC cipher unit.
`default_nettype none
package spncbc_pkg;

  localparam int unsigned ROUNDS     = 14;
  localparam int unsigned RND_W      = $clog2(ROUNDS);
  localparam int unsigned KEY_WORDS  = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // Rotation amounts of the mix and the key schedule
  localparam int unsigned ROT_MIX_A  = 21;
  localparam int unsigned ROT_MIX_B  = 6;
  localparam int unsigned ROT_ACC    = 10;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_A     = 3'd0,
    REG_KEY_B     = 3'd1,
    REG_KEY_C     = 3'd2,
    REG_KEY_D     = 3'd3,
    REG_KEY_COUNT = 3'd4,
    REG_IV_HIGH   = 3'd5,
    REG_IV_LOW    = 3'd6,
    REG_DIRECTION = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY_INIT,
    ST_KEY_SW,
    ST_KEY_ACC,
    ST_RND_A,
    ST_RND_B,
    ST_FINISH
  } state_t;

  // Four 32-bit words, word 0 first
  typedef logic [0:3][31:0] block_t;

  function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned n);
    rol32 = (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

  // Affine byte map: forward 113 + 93x, inverse 219 + 245y (mod 256)
  function automatic logic [31:0] sub_word(input logic [31:0] w, input logic inv);
    logic [31:0] o;
    logic [7:0]  b;
    o = '0;
    for (int s = 0; s < 4; s++) begin
      b = w[s*8 +: 8];
      if (inv) begin
        b = 8'd219 + 8'(b * 8'd245);
      end else begin
        b = 8'd113 + 8'(b * 8'd93);
      end
      o[s*8 +: 8] = b;
    end
    sub_word = o;
  endfunction

endpackage
`default_nettype wire

/* hdl/spncbc_in_if.sv */
// Interface: input block channel.
`default_nettype none
interface spncbc_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_high;
  logic [63:0] block_low;
  logic        first_block;

  modport source (output valid, block_high, block_low, first_block, input ready);
  modport sink (input valid, block_high, block_low, first_block, output ready);
endinterface
`default_nettype wire

/* hdl/spncbc_out_if.sv */
// Interface: result block channel.
`default_nettype none
interface spncbc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;

  modport source (output valid, result_high, result_low, input ready);
  modport sink (input valid, result_high, result_low, output ready);
endinterface
`default_nettype wire

/* hdl/spn_block_cipher_cbc_unit.sv */
// Top level: iterative 128-bit SPN block cipher with CBC chaining and key schedule.
//
// Usage:
//   in_ch  (sink)   : one 128-bit block per transaction; first_block reloads the
//                     chain value from the IV before the block is processed.
//   out_ch (source) : one 128-bit result per input transaction, in order.
//   cfg_*           : write-only registers (key words, key count, IV, direction),
//                     to be written only while the unit is idle; the unit does not enforce this.
// Timing: a block runs through the shared round unit, each round split into the
//   half-mix states RND_A and RND_B, and then loads the result register in FINISH.
//   After reset or any key/count write, the next block first runs the key schedule:
//   KEY_INIT loads round keys 0 and 13, then KEY_SW/KEY_ACC build rows 1 to 12.
// Blocks are taken one at a time, since the single round unit is shared;
//   in_ch.ready is high only while the unit is idle.
// Reset (rst_n, synchronous): keys marked invalid, chain value zero, key count 8.
// Stall: a finished result waits in the output register; a following block may
//   be taken and processed, and its result waits until the register frees.
`default_nettype none
module spn_block_cipher_cbc_unit (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  spncbc_in_if.sink                                  in_ch,
  spncbc_out_if.source                               out_ch,
  input  wire logic                                  cfg_we,
  input  wire logic [spncbc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [spncbc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int unsigned RW = spncbc_pkg::RND_W;
  localparam logic [RW-1:0] RND_LAST = RW'(spncbc_pkg::ROUNDS - 1);
  localparam logic [RW-1:0] KEY_LAST_ROW = RW'(spncbc_pkg::ROUNDS - 2);

  // Configuration registers
  logic [63:0] key_a_r, key_b_r, key_c_r, key_d_r, iv_high_r, iv_low_r;
  logic [3:0]  key_cnt_r;
  logic        dir_r;
  logic        keys_valid_r;

  // Control
  spncbc_pkg::state_t state_r, state_nxt;
  logic [RW-1:0] rnd_r;
  logic [2:0]    step_r;
  logic          run_dir_r;

  // Key schedule store and work rings
  spncbc_pkg::block_t rk_r [spncbc_pkg::ROUNDS];
  logic [31:0]        sw_r  [spncbc_pkg::KEY_WORDS];
  logic [31:0]        acc_r [spncbc_pkg::KEY_WORDS];
  spncbc_pkg::block_t kw_r, prev_r;

  // Block datapath
  spncbc_pkg::block_t m_r, saved_r, chain_r, res_r;
  logic               out_valid_r;

  logic               accept, out_free, last_rnd;
  spncbc_pkg::block_t blk_in, iv_blk, chain_sel, rk_cur;
  logic [3:0]         cnt_eff;
  logic [31:0]        key_word [spncbc_pkg::KEY_WORDS];
  logic [31:0]        sw_new, acc_f, k_new;
  spncbc_pkg::block_t kw_nxt;
  spncbc_pkg::block_t ea, eb, da, db;

  // Handshake and selection
  assign accept    = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign blk_in    = {in_ch.block_high, in_ch.block_low};
  assign iv_blk    = {iv_high_r, iv_low_r};
  assign chain_sel = in_ch.first_block ? iv_blk : chain_r;
  assign rk_cur    = rk_r[rnd_r];
  assign last_rnd  = run_dir_r ? (rnd_r == '0) : (rnd_r == RND_LAST);
  assign cnt_eff   = (key_cnt_r > 4'd8) ? 4'd8 : key_cnt_r;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_high = {res_r[0], res_r[1]};
  assign out_ch.result_low  = {res_r[2], res_r[3]};

  // Key words with the count applied
  always_comb begin
    key_word[0] = key_a_r[63:32];
    key_word[1] = key_a_r[31:0];
    key_word[2] = key_b_r[63:32];
    key_word[3] = key_b_r[31:0];
    key_word[4] = key_c_r[63:32];
    key_word[5] = key_c_r[31:0];
    key_word[6] = key_d_r[63:32];
    key_word[7] = key_d_r[31:0];
    for (int i = 0; i < spncbc_pkg::KEY_WORDS; i++) begin
      if (4'(i) >= cnt_eff) key_word[i] = '0;
    end
  end

  // Schedule unit: word update, then key and accumulator update
  always_comb begin
    sw_new = sw_r[0] + spncbc_pkg::rol32(sw_r[1], spncbc_pkg::ROT_MIX_A) + prev_r[0];
    acc_f  = (sw_r[0] + acc_r[0]) ^ spncbc_pkg::ror32(acc_r[0], spncbc_pkg::ROT_ACC)
             ^ spncbc_pkg::rol32(sw_r[0], spncbc_pkg::ROT_MIX_A);
    k_new  = kw_r[0] + acc_f;
    kw_nxt = {kw_r[1], kw_r[2], kw_r[3], k_new};
  end

  // Round unit, encrypt: substitution, word rotate, first half of mix
  always_comb begin
    spncbc_pkg::block_t s;
    for (int i = 0; i < 4; i++) s[i] = spncbc_pkg::sub_word(m_r[i], 1'b0);
    ea[0] = s[1] + s[2];
    ea[2] = s[3] + ea[0];
    ea[1] = spncbc_pkg::rol32(s[2] + s[0], spncbc_pkg::ROT_MIX_A);
    ea[3] = spncbc_pkg::rol32(s[0] + ea[2], spncbc_pkg::ROT_MIX_B);
  end

  // Encrypt: second half of mix and round key
  always_comb begin
    spncbc_pkg::block_t c;
    c[0] = m_r[0] + m_r[2];
    c[1] = m_r[1] + m_r[3];
    c[2] = m_r[2] + c[0];
    c[3] = m_r[3] + c[1];
    for (int i = 0; i < 4; i++) eb[i] = c[i] ^ rk_cur[i];
  end

  // Decrypt: round key and undo second half of mix
  always_comb begin
    spncbc_pkg::block_t x;
    for (int i = 0; i < 4; i++) x[i] = m_r[i] ^ rk_cur[i];
    x[3] = x[3] - x[1];
    x[2] = x[2] - x[0];
    x[1] = x[1] - x[3];
    x[0] = x[0] - x[2];
    da[0] = x[0];
    da[2] = x[2];
    da[1] = spncbc_pkg::ror32(x[1], spncbc_pkg::ROT_MIX_A);
    da[3] = spncbc_pkg::ror32(x[3], spncbc_pkg::ROT_MIX_B);
  end

  // Decrypt: undo first half, word rotate, inverse substitution
  always_comb begin
    spncbc_pkg::block_t x;
    x[3] = m_r[3] - m_r[2];
    x[1] = m_r[1] - x[3];
    x[2] = m_r[2] - m_r[0];
    x[0] = m_r[0] - x[1];
    db[0] = spncbc_pkg::sub_word(x[3], 1'b1);
    db[1] = spncbc_pkg::sub_word(x[0], 1'b1);
    db[2] = spncbc_pkg::sub_word(x[1], 1'b1);
    db[3] = spncbc_pkg::sub_word(x[2], 1'b1);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spncbc_pkg::ST_IDLE: begin
        if (accept) state_nxt = keys_valid_r ? spncbc_pkg::ST_RND_A : spncbc_pkg::ST_KEY_INIT;
      end
      spncbc_pkg::ST_KEY_INIT: state_nxt = spncbc_pkg::ST_KEY_SW;
      spncbc_pkg::ST_KEY_SW:   state_nxt = spncbc_pkg::ST_KEY_ACC;
      spncbc_pkg::ST_KEY_ACC: begin
        if (step_r == 3'd7 && rnd_r == KEY_LAST_ROW) state_nxt = spncbc_pkg::ST_RND_A;
        else state_nxt = spncbc_pkg::ST_KEY_SW;
      end
      spncbc_pkg::ST_RND_A:    state_nxt = spncbc_pkg::ST_RND_B;
      spncbc_pkg::ST_RND_B:    state_nxt = last_rnd ? spncbc_pkg::ST_FINISH : spncbc_pkg::ST_RND_A;
      spncbc_pkg::ST_FINISH:   if (out_free) state_nxt = spncbc_pkg::ST_IDLE;
      default:                 state_nxt = spncbc_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    case (state_r)
      spncbc_pkg::ST_IDLE: in_ch.ready = 1'b1;
      default:             in_ch.ready = 1'b0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= spncbc_pkg::ST_IDLE;
      key_cnt_r    <= 4'd8;
      dir_r        <= 1'b0;
      keys_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      rnd_r        <= '0;
      step_r       <= '0;
      run_dir_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          spncbc_pkg::REG_KEY_A, spncbc_pkg::REG_KEY_B,
          spncbc_pkg::REG_KEY_C, spncbc_pkg::REG_KEY_D: keys_valid_r <= 1'b0;
          spncbc_pkg::REG_KEY_COUNT: begin
            key_cnt_r    <= cfg_data[3:0];
            keys_valid_r <= 1'b0;
          end
          spncbc_pkg::REG_DIRECTION: dir_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_ch.ready && !(state_r == spncbc_pkg::ST_FINISH && out_free)) out_valid_r <= 1'b0;
      case (state_r)
        spncbc_pkg::ST_IDLE: begin
          if (accept) begin
            run_dir_r <= dir_r;
            rnd_r     <= dir_r ? RND_LAST : '0;
          end
        end
        spncbc_pkg::ST_KEY_INIT: begin
          rnd_r  <= RW'(1);
          step_r <= '0;
        end
        spncbc_pkg::ST_KEY_ACC: begin
          step_r <= step_r + 3'd1;
          if (step_r == 3'd7) begin
            if (rnd_r == KEY_LAST_ROW) begin
              keys_valid_r <= 1'b1;
              rnd_r        <= run_dir_r ? RND_LAST : '0;
            end else begin
              rnd_r <= rnd_r + RW'(1);
            end
          end
        end
        spncbc_pkg::ST_RND_B: begin
          if (!last_rnd) rnd_r <= run_dir_r ? rnd_r - RW'(1) : rnd_r + RW'(1);
        end
        spncbc_pkg::ST_FINISH: if (out_free) out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // Configuration payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_a_r   <= '0;
      key_b_r   <= '0;
      key_c_r   <= '0;
      key_d_r   <= '0;
      iv_high_r <= '0;
      iv_low_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        spncbc_pkg::REG_KEY_A:   key_a_r   <= cfg_data;
        spncbc_pkg::REG_KEY_B:   key_b_r   <= cfg_data;
        spncbc_pkg::REG_KEY_C:   key_c_r   <= cfg_data;
        spncbc_pkg::REG_KEY_D:   key_d_r   <= cfg_data;
        spncbc_pkg::REG_IV_HIGH: iv_high_r <= cfg_data;
        spncbc_pkg::REG_IV_LOW:  iv_low_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Chain value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= '0;
    end else if (state_r == spncbc_pkg::ST_IDLE && accept) begin
      chain_r <= chain_sel;
    end else if (state_r == spncbc_pkg::ST_FINISH && out_free) begin
      chain_r <= run_dir_r ? saved_r : m_r;
    end
  end

  // Block, schedule and round key datapath
  always_ff @(posedge clk) begin
    case (state_r)
      spncbc_pkg::ST_IDLE: begin
        if (accept) begin
          saved_r <= blk_in;
          for (int i = 0; i < 4; i++) begin
            m_r[i] <= dir_r ? blk_in[i] : blk_in[i] ^ chain_sel[i];
          end
        end
      end
      spncbc_pkg::ST_KEY_INIT: begin
        for (int i = 0; i < spncbc_pkg::KEY_WORDS; i++) begin
          sw_r[i]  <= key_word[i];
          acc_r[i] <= '0;
        end
        for (int i = 0; i < 4; i++) begin
          rk_r[0][i]                     <= key_word[i];
          rk_r[spncbc_pkg::ROUNDS-1][i]  <= key_word[4+i];
          prev_r[i]                      <= key_word[i];
        end
        kw_r <= '0;
      end
      spncbc_pkg::ST_KEY_SW: sw_r[0] <= sw_new;
      spncbc_pkg::ST_KEY_ACC: begin
        for (int i = 0; i < spncbc_pkg::KEY_WORDS - 1; i++) begin
          sw_r[i]  <= sw_r[i+1];
          acc_r[i] <= acc_r[i+1];
        end
        sw_r[spncbc_pkg::KEY_WORDS-1]  <= sw_r[0];
        acc_r[spncbc_pkg::KEY_WORDS-1] <= acc_r[0] + k_new;
        if (step_r == 3'd7) begin
          rk_r[rnd_r] <= kw_nxt;
          prev_r      <= kw_nxt;
          kw_r        <= '0;
        end else begin
          kw_r   <= kw_nxt;
          prev_r <= {prev_r[1], prev_r[2], prev_r[3], prev_r[0]};
        end
      end
      spncbc_pkg::ST_RND_A: m_r <= run_dir_r ? da : ea;
      spncbc_pkg::ST_RND_B: m_r <= run_dir_r ? db : eb;
      spncbc_pkg::ST_FINISH: begin
        if (out_free) begin
          for (int i = 0; i < 4; i++) res_r[i] <= run_dir_r ? m_r[i] ^ chain_r[i] : m_r[i];
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  // Round unit never runs on a stale key schedule
  a_keys_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == spncbc_pkg::ST_RND_A) |-> keys_valid_r)
    else $error("round started without valid keys");

  // A result is only loaded from the finish state
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == spncbc_pkg::ST_FINISH))
    else $error("result loaded outside finish");

  // Finish never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> $stable(res_r))
    else $error("pending result overwritten");

  // Key row counter stays inside the schedule while expanding
  a_key_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == spncbc_pkg::ST_KEY_ACC) |-> (rnd_r != '0 && rnd_r <= KEY_LAST_ROW))
    else $error("key row out of range");
`endif

endmodule
`default_nettype wire

/* dv/spncbc_tb_if.sv */
// Testbench-side note: channel interfaces come from the RTL; this file holds shared tb types.
`timescale 1ns / 100ps
package spncbc_tb_pkg;
  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        first_block;
  } blk_item_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } blk_result_t;
endpackage

/* dv/spn_block_cipher_cbc_unit_tb.sv */
// Testbench: random and directed CBC blocks against an in-bench cipher predictor.
`timescale 1ns / 100ps
module spn_block_cipher_cbc_unit_tb;

  localparam int NRND = 14;
  localparam int LIMIT = 2000000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [63:0] cfg_data;

  spncbc_in_if in_ch ();
  spncbc_out_if out_ch ();

  spn_block_cipher_cbc_unit u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow configuration and cipher state
  logic [63:0] key_reg [4];
  logic [3:0]  kcount;
  logic [63:0] ivh, ivl;
  logic        dir_dec;
  logic        keys_ok;
  logic [31:0] rkeys [NRND*4];
  logic [31:0] chain [4];

  spncbc_tb_pkg::blk_item_t   pending_blocks[$];
  spncbc_tb_pkg::blk_result_t expected_blocks[$];
  int          mismatch_cnt;
  int          cycle_cnt;
  int          in_gap, out_gap;

  function automatic logic [31:0] rotl(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sbox_word(logic [31:0] w, logic inv);
    logic [31:0] o;
    logic [7:0]  b;
    for (int s = 0; s < 4; s++) begin
      b = w[s*8 +: 8];
      b = inv ? 8'(8'd219 + 8'(b * 8'd245)) : 8'(8'd113 + 8'(b * 8'd93));
      o[s*8 +: 8] = b;
    end
    return o;
  endfunction

  // Add-rotate-xor key schedule
  task automatic build_round_keys();
    logic [31:0] sw [8];
    logic [31:0] sa [8];
    logic [31:0] s, a;
    int cnt;
    int idx;
    cnt = (kcount > 8) ? 8 : kcount;
    for (int i = 0; i < 8; i++) begin
      sw[i] = (i < cnt) ? ((i & 1) ? key_reg[i>>1][31:0] : key_reg[i>>1][63:32]) : 32'd0;
      sa[i] = 32'd0;
    end
    for (int i = 0; i < NRND*4; i++) rkeys[i] = 32'd0;
    for (int i = 0; i < 4; i++) begin
      rkeys[i] = sw[i];
      rkeys[(NRND-1)*4 + i] = sw[4+i];
    end
    for (int r = 1; r + 1 < NRND; r++) begin
      for (int i = 0; i < 8; i++) begin
        idx = r*4 + (i & 3);
        sw[i] = sw[i] + rotl(sw[(i+1) & 7], 21) + rkeys[(r-1)*4 + (i & 3)];
        s = sw[i];
        a = sa[i];
        rkeys[idx] = rkeys[idx] + ((s + a) ^ (rotr(a, 10) ^ rotl(s, 21)));
        sa[i] = sa[i] + rkeys[idx];
      end
    end
    keys_ok = 1'b1;
  endtask

  // Predict one CBC block and update chain
  task automatic predict_block(spncbc_tb_pkg::blk_item_t it);
    logic [31:0] m [4];
    logic [31:0] keep [4];
    logic [31:0] t;
    spncbc_tb_pkg::blk_result_t res;
    if (!keys_ok) build_round_keys();
    if (it.first_block) begin
      chain[0] = ivh[63:32]; chain[1] = ivh[31:0];
      chain[2] = ivl[63:32]; chain[3] = ivl[31:0];
    end
    m[0] = it.block_high[63:32]; m[1] = it.block_high[31:0];
    m[2] = it.block_low[63:32];  m[3] = it.block_low[31:0];
    if (!dir_dec) begin
      for (int i = 0; i < 4; i++) m[i] ^= chain[i];
      for (int r = 0; r < NRND; r++) begin
        for (int i = 0; i < 4; i++) m[i] = sbox_word(m[i], 1'b0);
        t = m[0]; m[0] = m[1]; m[1] = m[2]; m[2] = m[3]; m[3] = t;
        m[0] += m[1]; m[2] += m[0]; m[1] += m[3]; m[3] += m[2];
        m[1] = rotl(m[1], 21); m[3] = rotl(m[3], 6);
        m[0] += m[2]; m[1] += m[3]; m[2] += m[0]; m[3] += m[1];
        for (int i = 0; i < 4; i++) m[i] ^= rkeys[r*4 + i];
      end
      for (int i = 0; i < 4; i++) chain[i] = m[i];
    end else begin
      for (int i = 0; i < 4; i++) keep[i] = m[i];
      for (int r = NRND - 1; r >= 0; r--) begin
        for (int i = 0; i < 4; i++) m[i] ^= rkeys[r*4 + i];
        m[3] -= m[1]; m[2] -= m[0]; m[1] -= m[3]; m[0] -= m[2];
        m[3] = rotr(m[3], 6); m[1] = rotr(m[1], 21);
        m[3] -= m[2]; m[1] -= m[3]; m[2] -= m[0]; m[0] -= m[1];
        t = m[3]; m[3] = m[2]; m[2] = m[1]; m[1] = m[0]; m[0] = t;
        for (int i = 0; i < 4; i++) m[i] = sbox_word(m[i], 1'b1);
      end
      for (int i = 0; i < 4; i++) begin
        m[i] ^= chain[i];
        chain[i] = keep[i];
      end
    end
    res.result_high = {m[0], m[1]};
    res.result_low  = {m[2], m[3]};
    expected_blocks.push_back(res);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Driver: pops pending blocks, random gaps between transactions
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap <= 0;
    end else if (in_ch.valid && in_ch.ready) begin
      predict_block(pending_blocks.pop_front());
      in_ch.valid <= 1'b0;
      in_gap <= $urandom_range(0, 6);
    end else if (!in_ch.valid) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
      end else if (pending_blocks.size() > 0) begin
        in_ch.valid       <= 1'b1;
        in_ch.block_high  <= pending_blocks[0].block_high;
        in_ch.block_low   <= pending_blocks[0].block_low;
        in_ch.first_block <= pending_blocks[0].first_block;
      end
    end
  end

  // Monitor: checks each result transaction, random ready stalls
  always @(posedge clk) begin
    spncbc_tb_pkg::blk_result_t exp_r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_blocks.size() == 0) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < 10) $display("unexpected result %h %h",
                                          out_ch.result_high, out_ch.result_low);
        end else begin
          exp_r = expected_blocks.pop_front();
          if (exp_r.result_high !== out_ch.result_high ||
              exp_r.result_low !== out_ch.result_low) begin
            mismatch_cnt <= mismatch_cnt + 1;
            if (mismatch_cnt < 10)
              $display("mismatch exp %h %h got %h %h", exp_r.result_high,
                       exp_r.result_low, out_ch.result_high, out_ch.result_low);
          end
        end
        out_gap <= $urandom_range(0, 6);
        out_ch.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic cfg_write(spncbc_pkg::cfg_reg_t idx, logic [63:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      spncbc_pkg::REG_KEY_A, spncbc_pkg::REG_KEY_B,
      spncbc_pkg::REG_KEY_C, spncbc_pkg::REG_KEY_D: begin
        key_reg[idx] = val;
        keys_ok = 1'b0;
      end
      spncbc_pkg::REG_KEY_COUNT: begin
        kcount = val[3:0];
        keys_ok = 1'b0;
      end
      spncbc_pkg::REG_IV_HIGH:   ivh = val;
      spncbc_pkg::REG_IV_LOW:    ivl = val;
      spncbc_pkg::REG_DIRECTION: dir_dec = val[0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_blocks.size() > 0 || in_ch.valid || expected_blocks.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic add_block(logic [63:0] h, logic [63:0] l, logic f);
    spncbc_tb_pkg::blk_item_t it;
    it.block_high = h;
    it.block_low = l;
    it.first_block = f;
    pending_blocks.push_back(it);
  endtask

  task automatic new_setting(int kc, logic d);
    for (int k = 0; k < 4; k++) cfg_write(spncbc_pkg::cfg_reg_t'(k), rand64());
    cfg_write(spncbc_pkg::REG_KEY_COUNT, 64'(kc));
    cfg_write(spncbc_pkg::REG_IV_HIGH, rand64());
    cfg_write(spncbc_pkg::REG_IV_LOW, rand64());
    cfg_write(spncbc_pkg::REG_DIRECTION, 64'(d));
  endtask

  logic [63:0] ph, pl;

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.block_high = '0;
    in_ch.block_low = '0;
    in_ch.first_block = 1'b0;
    out_ch.ready = 1'b0;
    mismatch_cnt = 0;
    cycle_cnt = 0;
    for (int k = 0; k < 4; k++) key_reg[k] = '0;
    kcount = 4'd8;
    ivh = '0;
    ivl = '0;
    dir_dec = 1'b0;
    keys_ok = 1'b0;
    for (int i = 0; i < 4; i++) chain[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset chain, extremes, chained blocks
    add_block('0, '0, 1'b0);
    add_block('1, '1, 1'b0);
    add_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1);
    add_block('1, '0, 1'b0);
    wait_idle();
    cfg_write(spncbc_pkg::REG_KEY_COUNT, 64'd15);
    cfg_write(spncbc_pkg::REG_KEY_A, '1);
    cfg_write(spncbc_pkg::REG_IV_HIGH, '1);
    cfg_write(spncbc_pkg::REG_IV_LOW, '1);
    add_block('0, '1, 1'b1);
    add_block('1, '1, 1'b0);
    wait_idle();
    cfg_write(spncbc_pkg::REG_KEY_COUNT, 64'd0);
    cfg_write(spncbc_pkg::REG_DIRECTION, 64'd1);
    add_block('0, '0, 1'b1);
    add_block('1, '1, 1'b0);
    wait_idle();
    cfg_write(spncbc_pkg::REG_KEY_D, '1);
    cfg_write(spncbc_pkg::REG_KEY_COUNT, 64'd8);
    add_block(rand64(), rand64(), 1'b1);
    add_block(rand64(), rand64(), 1'b0);
    wait_idle();

    // Random phases over settings, both directions, key counts 0..15
    for (int p = 0; p < 30; p++) begin
      new_setting((p < 2) ? p * 8 : $urandom_range(0, 15), p[0]);
      for (int n = 0; n < 50; n++) begin
        ph = rand64();
        pl = rand64();
        add_block(ph, pl, (n == 0) || ($urandom_range(0, 15) == 0));
      end
      if (p == 5) wait_idle();
      else if ($urandom_range(0, 1)) wait_idle();
      else begin
        while (pending_blocks.size() > 0 || in_ch.valid) @(posedge clk);
        wait_idle();
      end
    end

    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

/* filelist.f */
hdl/spncbc_pkg.sv
hdl/spncbc_in_if.sv
hdl/spncbc_out_if.sv
hdl/spn_block_cipher_cbc_unit.sv
dv/spncbc_tb_if.sv
dv/spn_block_cipher_cbc_unit_tb.sv
